>>> rtl/utf8d_pkg.sv
// Shared types and constants of the UTF-8 stream decoder.
package utf8d_pkg;

  localparam int CP_W           = 21;
  localparam int CNT_W          = 3;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;

  // One decoded item as it travels from the front to the back: a burst of
  // cnt results, all U+FFFD except the last, which carries last_cp/last_has.
  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [CP_W-1:0]  last_cp;
    logic             last_has;
    logic             eos;
  } cmd_t;

endpackage

>>> rtl/utf8d_if.sv
// Valid/ready channel interfaces for the byte input and the code point output.
interface utf8d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_string;

  modport source (output valid, output data_byte, output end_of_string, input ready);
  modport sink   (input valid, input data_byte, input end_of_string, output ready);
endinterface

interface utf8d_out_if import utf8d_pkg::*;;
  logic            valid;
  logic            ready;
  logic [CP_W-1:0] code_point;
  logic            has_char;
  logic            string_done;
  logic            last_of_item;

  modport source (output valid, output code_point, output has_char, output string_done,
                  output last_of_item, input ready);
  modport sink   (input valid, input code_point, input has_char, input string_done,
                  input last_of_item, output ready);
endinterface

>>> rtl/utf8d_front.sv
// Front end: accepts bytes, tracks the open sequence and builds at most one burst command per byte.
module utf8d_front import utf8d_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_head_only,
  utf8d_in_if.sink     in_chan,
  input  logic         q_full,
  output logic         push,
  output cmd_t         push_cmd
);

  logic        head_only_r;
  logic [4:0]  lead_r, lead_nxt;
  logic [1:0]  seq_r, seq_nxt;
  logic [1:0]  ch_r, ch_nxt;
  logic [17:0] pp_r, pp_nxt;
  logic        hf_r, hf_nxt;

  logic [7:0]  b;
  logic        eos;
  logic        accept;
  logic        is_cont, is_ascii, is_lead2, is_lead3, is_lead4;
  logic [17:0] pp_ext;
  logic [1:0]  ch_inc;
  logic [CP_W-1:0] cp_done;

  logic [CNT_W-1:0] raw_n;
  logic [3:0]       raw_ends;
  logic [CP_W-1:0]  raw_last;
  logic [CNT_W-1:0] keep_n;

  assign b         = in_chan.data_byte;
  assign eos       = in_chan.end_of_string;
  assign in_chan.ready = !q_full;
  assign accept    = in_chan.valid && !q_full;
  assign cfg_ready = 1'b1;

  // Classify the byte
  assign is_cont  = (b[7:6] == 2'b10);
  assign is_ascii = !b[7];
  assign is_lead2 = (b[7:5] == 3'b110);
  assign is_lead3 = (b[7:4] == 4'b1110);
  assign is_lead4 = (b[7:3] == 5'b11110);

  assign pp_ext = {pp_r[11:0], b[5:0]};
  assign ch_inc = ch_r + 2'd1;

  // Assemble the completed code point from lead and continuation bits
  always_comb begin
    case (seq_r)
      2'd1:    cp_done = {10'b0, lead_r, pp_ext[5:0]};
      2'd2:    cp_done = {4'b0, lead_r, pp_ext[11:0]};
      2'd3:    cp_done = {lead_r[2:0], pp_ext};
      default: cp_done = '0;
    endcase
  end

  // Build the raw result list and the next sequence state
  always_comb begin
    raw_n    = '0;
    raw_ends = '0;
    raw_last = REPLACEMENT_CP;
    seq_nxt  = seq_r;
    ch_nxt   = ch_r;
    lead_nxt = lead_r;
    pp_nxt   = pp_r;

    if (seq_r != 2'd0 && is_cont) begin
      pp_nxt = pp_ext;
      ch_nxt = ch_inc;
      if (ch_inc >= seq_r) begin
        raw_ends[0] = 1'b1;
        raw_n       = 3'd1;
        raw_last    = cp_done;
        seq_nxt     = '0;
        ch_nxt      = '0;
        lead_nxt    = '0;
        pp_nxt      = '0;
      end
    end else begin
      // Broken sequence: lead's U+FFFD, then one per held continuation
      if (seq_r != 2'd0) begin
        raw_n = 3'd1;
        for (int k = 0; k < 2; k++) begin
          if (2'(k) < ch_r) begin
            raw_ends[raw_n[1:0]] = 1'b1;
            raw_n = raw_n + 3'd1;
          end
        end
        seq_nxt  = '0;
        ch_nxt   = '0;
        lead_nxt = '0;
        pp_nxt   = '0;
      end
      // Decode the byte afresh
      if (is_ascii) begin
        raw_ends[raw_n[1:0]] = 1'b1;
        raw_n    = raw_n + 3'd1;
        raw_last = {13'b0, b};
      end else if (is_lead2) begin
        seq_nxt  = 2'd1;
        lead_nxt = b[4:0];
        ch_nxt   = '0;
        pp_nxt   = '0;
      end else if (is_lead3) begin
        seq_nxt  = 2'd2;
        lead_nxt = {1'b0, b[3:0]};
        ch_nxt   = '0;
        pp_nxt   = '0;
      end else if (is_lead4) begin
        seq_nxt  = 2'd3;
        lead_nxt = {2'b0, b[2:0]};
        ch_nxt   = '0;
        pp_nxt   = '0;
      end else begin
        raw_ends[raw_n[1:0]] = 1'b1;
        raw_n    = raw_n + 3'd1;
        raw_last = REPLACEMENT_CP;
      end
    end

    // Truncated at end of string: flush what is still open
    if (eos && seq_nxt != 2'd0) begin
      raw_n    = raw_n + 3'd1;
      raw_last = REPLACEMENT_CP;
      for (int k = 0; k < 2; k++) begin
        if (2'(k) < ch_nxt) begin
          raw_ends[raw_n[1:0]] = 1'b1;
          raw_n = raw_n + 3'd1;
        end
      end
    end
  end

  // Drop results past the end of the head; survivors are always a prefix
  always_comb begin
    hf_nxt = hf_r;
    keep_n = '0;
    for (int p = 0; p < 4; p++) begin
      if (3'(p) < raw_n && !hf_nxt) begin
        keep_n = keep_n + 3'd1;
        if (raw_ends[p] && head_only_r) hf_nxt = 1'b1;
      end
    end
  end

  // Form the burst command; a silent end becomes a bare marker
  always_comb begin
    push_cmd.eos = eos;
    if (keep_n == '0) begin
      push_cmd.cnt      = 3'd1;
      push_cmd.last_cp  = '0;
      push_cmd.last_has = 1'b0;
    end else begin
      push_cmd.cnt      = keep_n;
      push_cmd.last_cp  = (keep_n == raw_n) ? raw_last : REPLACEMENT_CP;
      push_cmd.last_has = 1'b1;
    end
  end

  assign push = accept && (keep_n != '0 || eos);

  // Hold the configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_only_r <= 1'b0;
    end else if (cfg_valid) begin
      head_only_r <= cfg_head_only;
    end
  end

  // Advance the sequence state on each transfer; clear it at end of string
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r  <= '0;
      ch_r   <= '0;
      lead_r <= '0;
      pp_r   <= '0;
      hf_r   <= 1'b0;
    end else if (accept) begin
      if (eos) begin
        seq_r  <= '0;
        ch_r   <= '0;
        lead_r <= '0;
        pp_r   <= '0;
        hf_r   <= 1'b0;
      end else begin
        seq_r  <= seq_nxt;
        ch_r   <= ch_nxt;
        lead_r <= lead_nxt;
        pp_r   <= pp_nxt;
        hf_r   <= hf_nxt;
      end
    end
  end

endmodule

>>> rtl/utf8d_queue.sv
// Command queue between the front and the back end.
module utf8d_queue import utf8d_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t head_cmd,
  output logic empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_QW = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_QW-1:0] FULL_CNT = CNT_QW'(DEPTH);

  cmd_t              slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_QW-1:0] count_r;

  assign full     = (count_r == FULL_CNT);
  assign empty    = (count_r == '0);
  assign head_cmd = slot_r[rd_ptr_r];

  // Store incoming commands
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
      if (pop)  rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
      if (push && !pop)      count_r <= count_r + CNT_QW'(1);
      else if (pop && !push) count_r <= count_r - CNT_QW'(1);
    end
  end

endmodule

>>> rtl/utf8d_back.sv
// Back end: expands each burst command into registered results, one per cycle unless stalled.
module utf8d_back import utf8d_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       empty,
  input  cmd_t       head_cmd,
  output logic       pop,
  utf8d_out_if.source out_chan
);

  logic [1:0]      idx_r, idx_nxt;
  logic            valid_r, valid_nxt;
  logic [CP_W-1:0] cp_r;
  logic            has_r, done_r, last_r;

  logic load, take, is_last;

  assign load    = !valid_r || out_chan.ready;
  assign take    = load && !empty;
  assign is_last = (({1'b0, idx_r} + 3'd1) == head_cmd.cnt);
  assign pop     = take && is_last;

  // Step through the burst; restart the index on the last result
  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (load) valid_nxt = !empty;
    if (take) idx_nxt = is_last ? 2'd0 : idx_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (take) begin
      cp_r   <= is_last ? head_cmd.last_cp : REPLACEMENT_CP;
      has_r  <= is_last ? head_cmd.last_has : 1'b1;
      done_r <= is_last && head_cmd.eos;
      last_r <= is_last;
    end
  end

  assign out_chan.valid        = valid_r;
  assign out_chan.code_point   = cp_r;
  assign out_chan.has_char     = has_r;
  assign out_chan.string_done  = done_r;
  assign out_chan.last_of_item = last_r;

endmodule

>>> rtl/utf8_stream_decoder.sv
// UTF-8 byte stream to code point decoder, top level.
// Path: an accepted byte's command is written into the command queue, and the back end loads
// its first result into the output register. Throughput: one byte per cycle while out_chan is
// ready and each byte yields at most one result; the command queue absorbs longer bursts.
// Reset: rst_n is synchronous, active low; it closes any open sequence, clears head_only,
// empties the queue and drops the output register.
module utf8_stream_decoder import utf8d_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_head_only,
  utf8d_in_if.sink    in_chan,
  utf8d_out_if.source out_chan
);

  logic push, pop, q_full, q_empty;
  cmd_t push_cmd, head_cmd;

  utf8d_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_head_only (cfg_head_only),
    .in_chan       (in_chan),
    .q_full        (q_full),
    .push          (push),
    .push_cmd      (push_cmd)
  );

  utf8d_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .head_cmd (head_cmd),
    .empty    (q_empty)
  );

  utf8d_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .empty    (q_empty),
    .head_cmd (head_cmd),
    .pop      (pop),
    .out_chan (out_chan)
  );

  // A string's final result always closes its byte's burst
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.string_done |-> out_chan.last_of_item)
    else $error("string_done without last_of_item");

  // A bare marker carries no code point and ends the string
  a_bare_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.has_char |->
      out_chan.code_point == '0 && out_chan.string_done)
    else $error("malformed end marker");

  // The back end never retires a command the queue does not hold
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_empty)
    else $error("queue underflow");

endmodule
